// ----- rtl/core/nkl_pkg.sv -----
// nkl_pkg: shared widths, operation codes, register indexes and control structs
// for the KL-divergence NMF update unit. No dependencies; every rtl/core file imports it.

package nkl_pkg;

    // operand and accumulator widths, Q format
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = 64;
    // magnitude of a product of two operands never exceeds 2^(2*DATA_W-2)
    localparam int NUM_W     = 2 * DATA_W - 1;
    // quotient bits kept by the divider; anything larger is flagged as overflow
    localparam int QUO_W     = DATA_W + 2;
    localparam int QCNT_W    = $clog2(QUO_W);
    // signed quotient plus one operand, with headroom
    localparam int SUM_W     = QUO_W + 2;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_MAX = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_MIN = CFG_IDX_W'(1);

    // 32-bit bounds, plain and sign-extended to accumulator width
    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ONE_LSB = DATA_W'(1);
    localparam logic signed [ACC_W-1:0]  S32_MAX_W =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  S32_MIN_W =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]  S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // operation codes; code 3 is undefined and yields a zero result
    typedef enum logic [1:0] {
        FUNC_DOT   = 2'd0,
        FUNC_DELTA = 2'd1,
        FUNC_APPLY = 2'd2
    } t_func;

    // one input request
    typedef struct packed {
        logic [1:0]               func;
        logic                     first;
        logic signed [DATA_W-1:0] a_value;
        logic signed [DATA_W-1:0] b_value;
        logic signed [DATA_W-1:0] acc_value;
        logic signed [DATA_W-1:0] norm_value;
        logic signed [DATA_W-1:0] obs;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic div_start;
        logic fin_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  den_zero;
        logic  div_done;
        logic  out_free;
    } t_sts;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_sat;

    // saturate a wide signed value to 32 bits
    function automatic t_sat sat32(input logic signed [ACC_W-1:0] v);
        t_sat r;
        if (v > S32_MAX_W) begin
            r.value = S32_MAX;
            r.sat   = 1'b1;
        end else if (v < S32_MIN_W) begin
            r.value = S32_MIN;
            r.sat   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/nkl_ifs.sv -----
// nkl_in_if / nkl_out_if: valid-ready request channels of the update unit.
// Depends on nkl_pkg for the operand width.

interface nkl_in_if import nkl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic                     first;
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
    logic signed [DATA_W-1:0] acc_value;
    logic signed [DATA_W-1:0] norm_value;
    logic signed [DATA_W-1:0] obs;

    modport source (
        output valid, func, first, a_value, b_value, acc_value, norm_value, obs,
        input  ready
    );
    modport sink (
        input  valid, func, first, a_value, b_value, acc_value, norm_value, obs,
        output ready
    );
endinterface

interface nkl_out_if import nkl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     div_zero;
    logic                     saturated;

    modport source (output valid, value, div_zero, saturated, input ready);
    modport sink   (input  valid, value, div_zero, saturated, output ready);
endinterface

// ----- rtl/core/nmf_kl_update_unit_top.sv -----
// nmf_kl_update_unit_top: KL-divergence NMF multiplicative update unit, Q16.16.
// Depends on nkl_pkg, nkl_ifs, nkl_ctrl, nkl_dpath and nkl_div.
//
//  channel   direction  handshake         payload
//  i_in      in         valid / ready     func, first, a_value, b_value,
//                                         acc_value, norm_value, obs
//  o_out     out        valid / ready     value, div_zero, saturated
//  cfg       in         i_cfg_we          i_cfg_idx, i_cfg_data
//
// Steps: dot, undefined and zero-divisor requests go through load, multiply,
// prepare and result; other delta and apply requests go through load, multiply,
// prepare, the divider steps, done and result. The radix-2 divider produces one
// quotient bit a cycle.
// One request is in flight at a time; the next is accepted while a result
// still waits in the output register, and the sequencer holds until it is taken.
// Reset is synchronous, active low: clears the dot accumulator, sets the clamps
// to the full 32-bit range and empties the output register.

module nmf_kl_update_unit_top import nkl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nkl_in_if.sink                i_in,
    nkl_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_sts  sts;
    t_item item;
    logic  in_ready;

    // gather the request payload
    assign item.func       = i_in.func;
    assign item.first      = i_in.first;
    assign item.a_value    = i_in.a_value;
    assign item.b_value    = i_in.b_value;
    assign item.acc_value  = i_in.acc_value;
    assign item.norm_value = i_in.norm_value;
    assign item.obs        = i_in.obs;
    assign i_in.ready      = in_ready;

    nkl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nkl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_value (o_out.value),
        .o_out_dz    (o_out.div_zero),
        .o_out_sat   (o_out.saturated)
    );

endmodule

// ----- rtl/core/nkl_div.sv -----
// nkl_div: radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Depends on nkl_pkg. Keeps QUO_W quotient bits and flags a larger quotient.

module nkl_div import nkl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DATA_W-1:0]       i_den,
    output logic                    o_done,
    output logic [QUO_W-1:0]        o_quo,
    output logic                    o_ovf
);

    localparam int HI_W = NUM_W - QUO_W;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic [DATA_W-1:0] r_rem,  n_rem;
    logic [DATA_W-1:0] r_den,  n_den;
    logic [QUO_W-1:0]  r_shf,  n_shf;
    logic              r_ovf,  n_ovf;

    logic [DATA_W-1:0] num_hi;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;
    logic              rem_ge;

    // upper numerator bits seed the remainder; the rest shift in bit by bit
    assign num_hi   = {{(DATA_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
    assign rem_sh   = {r_rem, r_shf[QUO_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = rem_sh >= {1'b0, r_den};

    // step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_shf  = r_shf;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = num_hi;
            n_den  = i_den;
            n_shf  = i_num[QUO_W-1:0];
            n_ovf  = num_hi >= i_den;
        end else if (r_busy) begin
            n_rem = rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            n_shf = {r_shf[QUO_W-2:0], rem_ge};
            n_cnt = r_cnt + QCNT_W'(1);
            if (r_cnt == QCNT_W'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_shf <= n_shf;
        r_ovf <= n_ovf;
    end

    assign o_done = r_done;
    assign o_quo  = r_shf;
    assign o_ovf  = r_ovf;

    // done only follows a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    // a new division never cuts into one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ----- rtl/core/nkl_ctrl.sv -----
// nkl_ctrl: sequencer of the update unit; issues datapath commands per request.
// Depends on nkl_pkg for t_cmd, t_sts and t_func.

module nkl_ctrl import nkl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   need_div;

    // delta and apply divide unless the divisor is zero
    assign need_div = ((i_sts.func == FUNC_DELTA) || (i_sts.func == FUNC_APPLY))
                      && !i_sts.den_zero;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no request is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one request at a time: an accepted request blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("second request taken while one is in flight");

endmodule

// ----- rtl/core/nkl_dpath.sv -----
// nkl_dpath: operand registers, multiplier, clamp, dot accumulator, divider and
// output register of the update unit. Depends on nkl_pkg and nkl_div.

module nkl_dpath import nkl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  t_item                    i_item,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic                     o_out_dz,
    output logic                     o_out_sat
);

    t_item                    r_item;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_den;
    logic signed [ACC_W-1:0]  r_dot;
    logic                     r_dot_sat;
    logic                     r_dz;
    logic                     r_neg;
    logic signed [DATA_W-1:0] r_pred_max;
    logic signed [DATA_W-1:0] r_pred_min;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_dz;
    logic                     r_out_sat;

    t_func                    func;
    logic signed [DATA_W-1:0] op_x, op_y;
    logic signed [ACC_W-1:0]  pred_hi, pred_lo;
    logic signed [DATA_W-1:0] den_sel;
    logic                     den_zero;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [DATA_W-1:0] den_abs;
    logic signed [ACC_W-1:0]  dot_base, dot_part;
    logic signed [ACC_W:0]    dot_sum;
    logic signed [ACC_W-1:0]  n_dot;
    logic                     n_dot_sat;
    logic                     div_done;
    logic [QUO_W-1:0]         quo;
    logic                     quo_ovf;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  delta_sum;
    t_sat                     dot_res, delta_res;
    logic signed [DATA_W-1:0] res_value;
    logic                     res_sat;
    logic                     out_free;

    assign func = t_func'(r_item.func);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_max <= S32_MAX;
            r_pred_min <= S32_MIN;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PRED_MAX) begin
                r_pred_max <= i_cfg_data;
            end else if (i_cfg_idx == CFG_PRED_MIN) begin
                r_pred_min <= i_cfg_data;
            end
        end
    end

    // multiplier operand selection
    always_comb begin
        case (func)
            FUNC_DOT: begin
                op_x = r_item.a_value;
                op_y = r_item.b_value;
            end
            FUNC_DELTA: begin
                op_x = r_item.b_value;
                op_y = r_item.obs;
            end
            FUNC_APPLY: begin
                op_x = r_item.a_value;
                op_y = r_item.acc_value;
            end
            default: begin
                op_x = r_item.a_value;
                op_y = r_item.b_value;
            end
        endcase
    end

    // pred clamp: limit to pred_max first, then raise to pred_min
    always_comb begin
        pred_hi = (r_dot > ACC_W'(r_pred_max)) ? ACC_W'(r_pred_max) : r_dot;
        pred_lo = (pred_hi < ACC_W'(r_pred_min)) ? ACC_W'(r_pred_min) : pred_hi;
        den_sel = (func == FUNC_DELTA) ? pred_lo[DATA_W-1:0] : r_item.norm_value;
    end

    // request, product and divisor registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.mul) begin
            r_prod <= op_x * op_y;
            r_den  <= den_sel;
        end
        if (i_cmd.prep) begin
            r_dz  <= den_zero;
            r_neg <= r_prod[PROD_W-1] ^ r_den[DATA_W-1];
        end
    end

    assign den_zero = (r_den == '0);

    // saturating dot accumulate of the floored product
    always_comb begin
        dot_base  = r_item.first ? '0 : r_dot;
        dot_part  = r_prod >>> FRAC_BITS;
        dot_sum   = {dot_base[ACC_W-1], dot_base} + {dot_part[ACC_W-1], dot_part};
        n_dot     = dot_sum[ACC_W-1:0];
        n_dot_sat = 1'b0;
        if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
            n_dot     = dot_sum[ACC_W] ? S64_MIN : S64_MAX;
            n_dot_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
        end else if (i_cmd.prep && (func == FUNC_DOT)) begin
            r_dot <= n_dot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep && (func == FUNC_DOT)) begin
            r_dot_sat <= n_dot_sat;
        end
    end

    // magnitudes for the divider
    assign prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign den_abs  = r_den[DATA_W-1] ? -r_den : r_den;

    nkl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (prod_abs[NUM_W-1:0]),
        .i_den   (den_abs),
        .o_done  (div_done),
        .o_quo   (quo),
        .o_ovf   (quo_ovf)
    );

    // result assembly
    always_comb begin
        q_signed  = r_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        delta_sum = SUM_W'(r_item.acc_value) + q_signed;
        dot_res   = sat32(r_dot);
        delta_res = sat32(ACC_W'(delta_sum));
        res_value = '0;
        res_sat   = 1'b0;
        case (func)
            FUNC_DOT: begin
                res_value = dot_res.value;
                res_sat   = dot_res.sat | r_dot_sat;
            end
            FUNC_DELTA: begin
                if (r_dz) begin
                    res_value = r_item.acc_value;
                end else if (quo_ovf) begin
                    res_value = r_neg ? S32_MIN : S32_MAX;
                    res_sat   = 1'b1;
                end else begin
                    res_value = delta_res.value;
                    res_sat   = delta_res.sat;
                end
            end
            FUNC_APPLY: begin
                if (r_dz) begin
                    res_value = r_item.a_value;
                end else if (quo_ovf) begin
                    // huge negative quotient floors to one LSB
                    res_value = r_neg ? ONE_LSB : S32_MAX;
                    res_sat   = !r_neg;
                end else if (q_signed > SUM_W'(S32_MAX)) begin
                    res_value = S32_MAX;
                    res_sat   = 1'b1;
                end else if (q_signed < SUM_W'(ONE_LSB)) begin
                    res_value = ONE_LSB;
                end else begin
                    res_value = q_signed[DATA_W-1:0];
                end
            end
            default: begin
                res_value = '0;
                res_sat   = 1'b0;
            end
        endcase
    end

    // output register: holds a finished result until taken
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_out_value <= res_value;
            r_out_dz    <= ((func == FUNC_DELTA) || (func == FUNC_APPLY)) && r_dz;
            r_out_sat   <= res_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_dz    = r_out_dz;
    assign o_out_sat   = r_out_sat;

    assign o_sts.func     = func;
    assign o_sts.den_zero = den_zero;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    // division only for delta or apply with a non-zero divisor
    a_div_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (((func == FUNC_DELTA) || (func == FUNC_APPLY))
                             && (r_den != '0)))
        else $error("divider started for a request that needs no division");

endmodule

// ----- bench/nmf_kl_update_unit_top_tb.sv -----
`timescale 1ns / 1ps
// nmf_kl_update_unit_top_tb: self-checking bench for the KL-NMF update unit (dot, delta, apply).
// Depends on nkl_pkg, nkl_ifs and the RTL under rtl/core; built-in predictor, random stalls.

module nmf_kl_update_unit_top_tb;
    import nkl_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RST_CYCLES    = 7;
    localparam int          RAND_ITEMS    = 2000;
    localparam int          SWEEP_LEN     = 40;      // full-scale products per run
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_PAUSE   = 60;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  FUNC_UNDEF    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = '1;
    localparam logic [DATA_W-1:0]    Q_ONE          = 32'h0001_0000;

    // expected outcome of one request; func kept for reports only
    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
        logic                     div_zero;
        logic                     saturated;
    } t_kl_due;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [DATA_W-1:0]     cfg_data;

    nkl_in_if  in_if ();
    nkl_out_if out_if ();

    nmf_kl_update_unit_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // predictor state and config copy
    logic signed [ACC_W-1:0]  dot_acc_model;
    logic signed [DATA_W-1:0] clamp_hi_model;
    logic signed [DATA_W-1:0] clamp_lo_model;

    t_item       req_backlog[$];
    t_kl_due     kl_results_due[$];
    t_item       cur_req;

    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int unsigned n_accepted   = 0;
    int unsigned hold_at      = 32'hFFFF_FFFF;
    int unsigned hold_left;
    logic        hold_fired;
    int unsigned quiet_cycles;
    int unsigned n_errors     = 0;
    int unsigned n_func[4]    = '{0, 0, 0, 0};
    int unsigned n_dz_seen    = 0;
    int unsigned n_sat_seen   = 0;

    // saturate to 32 bits, keeping any flag already raised
    function automatic t_kl_due fit_s32(input logic signed [ACC_W-1:0] v, input t_kl_due r);
        if (v > S32_MAX_W) begin
            r.value     = S32_MAX;
            r.saturated = 1'b1;
        end else if (v < S32_MIN_W) begin
            r.value     = S32_MIN;
            r.saturated = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // expected result of one request; updates the dot accumulator copy
    function automatic t_kl_due kl_unit_predict(input t_item req);
        t_kl_due                 r;
        logic signed [ACC_W-1:0] a, b, acc, norm, obs, prod, pred, q;
        logic [ACC_W:0]          dot_sum;
        a    = req.a_value;
        b    = req.b_value;
        acc  = req.acc_value;
        norm = req.norm_value;
        obs  = req.obs;
        r    = '0;
        r.func = req.func;
        case (req.func)
            FUNC_DOT: begin
                prod = (a * b) >>> FRAC_BITS;
                if (req.first)
                    dot_acc_model = '0;
                dot_sum = {dot_acc_model[ACC_W-1], dot_acc_model} + {prod[ACC_W-1], prod};
                if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
                    dot_acc_model = dot_sum[ACC_W] ? S64_MIN : S64_MAX;
                    r.saturated   = 1'b1;
                end else begin
                    dot_acc_model = dot_sum[ACC_W-1:0];
                end
                r = fit_s32(dot_acc_model, r);
            end
            FUNC_DELTA: begin
                // upper clamp first, so a reversed pair leaves pred at the lower bound
                pred = dot_acc_model;
                if (pred > clamp_hi_model)
                    pred = clamp_hi_model;
                if (pred < clamp_lo_model)
                    pred = clamp_lo_model;
                if (pred == 0) begin
                    r.value    = req.acc_value;
                    r.div_zero = 1'b1;
                end else begin
                    q = (b * obs) / pred;
                    r = fit_s32(acc + q, r);
                end
            end
            FUNC_APPLY: begin
                if (norm == 0) begin
                    r.value    = req.a_value;
                    r.div_zero = 1'b1;
                end else begin
                    q = (a * acc) / norm;
                    if (q > S32_MAX_W) begin
                        q           = S32_MAX_W;
                        r.saturated = 1'b1;
                    end
                    // epsilon floor: anything under one LSB becomes one LSB
                    if (q < 1)
                        q = 1;
                    r.value = q[DATA_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_item mk_req(input logic [1:0] func, input logic first,
                                     input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                     input logic [DATA_W-1:0] acc,
                                     input logic [DATA_W-1:0] norm,
                                     input logic [DATA_W-1:0] obs);
        t_item r;
        r.func       = func;
        r.first      = first;
        r.a_value    = a;
        r.b_value    = b;
        r.acc_value  = acc;
        r.norm_value = norm;
        r.obs        = obs;
        return r;
    endfunction

    // operand mix: mostly small Q16.16 values, some full-range words and corner values
    function automatic logic [DATA_W-1:0] rand_q();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return S32_MIN;
                    1:       return S32_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return Q_ONE;
                endcase
            end
            1, 2:    return $urandom();
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // register write at the rising edge; the predictor copy follows at once (block is idle)
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_PRED_MAX: clamp_hi_model = data;
            CFG_PRED_MIN: clamp_lo_model = data;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every request is through and every result is back, then a short pause
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (req_backlog.size() != 0 || in_if.valid || kl_results_due.size() != 0);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    // one random phase: mostly edge-shaped sequences (dot run, deltas, applies), some noise
    task automatic run_random_phase(input int n, input int src_pct, input int snk_pct,
                                    input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] lo);
        int unsigned base;
        int unsigned k;
        write_reg(CFG_PRED_MAX, hi);
        write_reg(CFG_PRED_MIN, lo);
        @(negedge i_clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        base = req_backlog.size();
        while (req_backlog.size() - base < n) begin
            if ($urandom_range(9) == 0) begin
                req_backlog.push_back(mk_req(2'($urandom_range(3)), 1'($urandom_range(1)),
                                             $urandom(), $urandom(), $urandom(), $urandom(),
                                             $urandom()));
            end else begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++)
                    req_backlog.push_back(mk_req(FUNC_DOT, i == 0 && $urandom_range(7) != 0,
                                                 rand_q(), rand_q(), rand_q(), rand_q(),
                                                 rand_q()));
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    req_backlog.push_back(mk_req(FUNC_DELTA, $urandom_range(3) == 0,
                                                 rand_q(), rand_q(), rand_q(), rand_q(),
                                                 rand_q()));
                k = $urandom_range(0, 2);
                for (int i = 0; i < k; i++)
                    req_backlog.push_back(mk_req(FUNC_APPLY, $urandom_range(3) == 0,
                                                 rand_q(), rand_q(), rand_q(), rand_q(),
                                                 rand_q()));
            end
        end
        wait_drained();
    endtask

    // request driver: holds while stalled, otherwise offers the next item or idles
    always @(posedge i_clk) begin : drv_proc
        t_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                kl_results_due.push_back(kl_unit_predict(cur_req));
                n_func[cur_req.func] = n_func[cur_req.func] + 1;
                n_accepted <= n_accepted + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt               = req_backlog.pop_front();
                    cur_req          <= nxt;
                    in_if.func       <= nxt.func;
                    in_if.first      <= nxt.first;
                    in_if.a_value    <= nxt.a_value;
                    in_if.b_value    <= nxt.b_value;
                    in_if.acc_value  <= nxt.acc_value;
                    in_if.norm_value <= nxt.norm_value;
                    in_if.obs        <= nxt.obs;
                    in_if.valid      <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, fired once when the accepted count reaches hold_at
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_fired && n_accepted >= hold_at) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
    end

    // result monitor: compare against the oldest outstanding expectation
    always @(posedge i_clk) begin : mon_proc
        t_kl_due due;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_dz_seen  = n_dz_seen + out_if.div_zero;
                n_sat_seen = n_sat_seen + out_if.saturated;
                if (kl_results_due.size() == 0) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: result %h dz %b sat %b with nothing outstanding",
                                 $realtime, out_if.value, out_if.div_zero, out_if.saturated);
                end else begin
                    due = kl_results_due.pop_front();
                    if (out_if.value !== due.value || out_if.div_zero !== due.div_zero ||
                        out_if.saturated !== due.saturated) begin
                        n_errors = n_errors + 1;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: func %0d mismatch value %h/%h dz %b/%b sat %b/%b %s",
                                     $realtime, due.func, due.value, out_if.value,
                                     due.div_zero, out_if.div_zero, due.saturated,
                                     out_if.saturated, "(expected/actual)");
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles with no request moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $realtime, QUIET_LIMIT, kl_results_due.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_if.valid      = 1'b0;
        in_if.func       = '0;
        in_if.first      = 1'b0;
        in_if.a_value    = '0;
        in_if.b_value    = '0;
        in_if.acc_value  = '0;
        in_if.norm_value = '0;
        in_if.obs        = '0;
        out_if.ready     = 1'b0;
        dot_acc_model    = '0;
        clamp_hi_model   = S32_MAX;
        clamp_lo_model   = S32_MIN;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 25;
        snk_idle_pct = 86;
        @(negedge i_clk);

        // directed corners under the reset clamps
        req_backlog.push_back(mk_req(FUNC_DOT, 1'b0, '0, '0, '0, '0, '0));
        // zero accumulator gives a zero divisor
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, 32'd1, 32'h0001_2345, '0, 32'd1));
        req_backlog.push_back(mk_req(FUNC_DOT, 1'b1, S32_MAX, S32_MAX, '0, '0, '0));
        req_backlog.push_back(mk_req(FUNC_DOT, 1'b0, S32_MIN, S32_MIN, '0, '0, '0));
        // accumulator far above pred_max, large positive sum
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, S32_MIN, S32_MAX, '0, S32_MIN));
        req_backlog.push_back(mk_req(FUNC_DOT, 1'b1, S32_MIN, S32_MAX, '0, '0, '0));
        // accumulator far below pred_min, large negative sum
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, S32_MAX, S32_MIN, '0, S32_MAX));
        // floor rounding of a negative product
        req_backlog.push_back(mk_req(FUNC_DOT, 1'b1, '1, 32'd1, '0, '0, '0));
        req_backlog.push_back(mk_req(FUNC_DOT, 1'b0, 32'h0002_0000, 32'h0001_8000, '0, '0, '0));
        // first flag on delta is ignored
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b1, '0, Q_ONE, 32'h0000_8000, '0,
                                     32'h0003_0000));
        req_backlog.push_back(mk_req(FUNC_APPLY, 1'b0, 32'h0002_0000, '0, Q_ONE,
                                     32'h0004_0000, '0));
        req_backlog.push_back(mk_req(FUNC_APPLY, 1'b0, S32_MIN, '0, Q_ONE, '0, '0));
        // negative and sub-LSB quotients take the epsilon floor
        req_backlog.push_back(mk_req(FUNC_APPLY, 1'b0, 32'hFFFF_0000, '0, Q_ONE, Q_ONE, '0));
        req_backlog.push_back(mk_req(FUNC_APPLY, 1'b0, 32'd1, '0, 32'd1, Q_ONE, '0));
        req_backlog.push_back(mk_req(FUNC_APPLY, 1'b0, S32_MAX, '0, S32_MAX, 32'd1, '0));
        req_backlog.push_back(mk_req(FUNC_APPLY, 1'b1, S32_MIN, '0, S32_MIN, S32_MIN, '0));
        // undefined code must leave the accumulator alone, first flag or not
        req_backlog.push_back(mk_req(FUNC_UNDEF, 1'b1, $urandom(), $urandom(), $urandom(),
                                     $urandom(), $urandom()));
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, Q_ONE, '0, '0, Q_ONE));
        wait_drained();

        // both clamps at zero: pred is always zero
        write_reg(CFG_PRED_MAX, '0);
        write_reg(CFG_PRED_MIN, '0);
        @(negedge i_clk);
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, Q_ONE, 32'h0000_4000, '0, Q_ONE));
        wait_drained();

        // reversed clamps: pred settles on pred_min; unused index must be ignored
        write_reg(CFG_PRED_MAX, Q_ONE);
        write_reg(CFG_PRED_MIN, 32'h0003_0000);
        write_reg(CFG_IDX_UNUSED, '0);
        @(negedge i_clk);
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, 32'h0003_0000, Q_ONE, '0, Q_ONE));
        wait_drained();

        // extreme reversed clamps
        write_reg(CFG_PRED_MAX, S32_MIN);
        write_reg(CFG_PRED_MIN, S32_MAX);
        @(negedge i_clk);
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, S32_MIN, '0, '0, S32_MIN));
        wait_drained();

        // random traffic under three clamp settings and three stall patterns
        run_random_phase(RAND_ITEMS * 35 / 100, 25, 86, S32_MAX, S32_MIN);
        run_random_phase(RAND_ITEMS * 35 / 100, 86, 25, 32'h0005_0000, Q_ONE);
        hold_at = n_accepted + 40;
        run_random_phase(RAND_ITEMS * 30 / 100, 0, 0, 32'h0008_0000, 32'd1);

        // runs of full-scale products push the accumulator far past the 32-bit range
        @(negedge i_clk);
        for (int i = 0; i < SWEEP_LEN; i++)
            req_backlog.push_back(mk_req(FUNC_DOT, i == 0, S32_MIN, S32_MIN, '0, '0, '0));
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, 32'h0004_0000, Q_ONE, '0,
                                     32'h0002_0000));
        for (int i = 0; i < SWEEP_LEN; i++)
            req_backlog.push_back(mk_req(FUNC_DOT, i == 0, S32_MIN, S32_MAX, '0, '0, '0));
        req_backlog.push_back(mk_req(FUNC_DELTA, 1'b0, '0, 32'h0004_0000, Q_ONE, '0,
                                     32'h0002_0000));
        wait_drained();

        n_errors = n_errors + kl_results_due.size();
        $display("Covered %0d requests: %0d dot, %0d delta, %0d apply, %0d undefined code;",
                 n_accepted, n_func[FUNC_DOT], n_func[FUNC_DELTA], n_func[FUNC_APPLY],
                 n_func[FUNC_UNDEF]);
        $display("%0d div_zero and %0d saturated results, clamps swept; %0d errors",
                 n_dz_seen, n_sat_seen, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/nkl_pkg.sv
rtl/core/nkl_ifs.sv
rtl/core/nkl_div.sv
rtl/core/nkl_ctrl.sv
rtl/core/nkl_dpath.sv
rtl/core/nmf_kl_update_unit_top.sv
bench/nmf_kl_update_unit_top_tb.sv
